### rtl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg: shared types and constants for the comparability counter
// Row type, cell data and cell control structs, cell modes, register indexes.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VW = $clog2(MAX_VERTICES);       // vertex index width
  localparam int CW = $clog2(MAX_VERTICES + 1);   // vertex count width

  localparam int REG_IDX_W = 2;
  localparam int REG_DATA_W = 7;

  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNDIRECTED   = 2'd1;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_CLOSE = 3'd1,
    MODE_CHECK = 3'd2,
    MODE_SHIFT = 3'd3,
    MODE_CLEAR = 3'd4
  } cell_mode_t;

  // contents of one cell: a matrix row, which row it is, and its comparable flag
  typedef struct packed {
    row_t          row;
    logic [VW-1:0] tag;
    logic          ok;
  } cell_data_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_mode_t    mode;
    logic [VW-1:0] step;
    logic [CW-1:0] live_n;
    logic          wr_a;
    logic          wr_b;
    logic          set_self;
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
  } cell_ctl_t;

endpackage

### rtl/graph_comparability_counter.sv
// ----------------------------------------------------------------------------
// graph_comparability_counter: reachability closure and comparability count
// Edge items load a bit adjacency matrix held in a ring of row cells; the
// last item runs a ring-rotating closure, a comparability check and a count.
// ----------------------------------------------------------------------------
// An item without last_edge leaves busy low, so such items go back to back.
// An item with last_edge raises busy for the closure, check and count, one
//   ring rotation each. done pulses in the same cycle as busy drops.
// The result is a one-cycle strobe; the receiver cannot stall it.
// Reset (rst, synchronous): matrix cleared, vertex_count 64, directed mode.
// ----------------------------------------------------------------------------
module graph_comparability_counter (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             wr_en,
  input  logic [gcc_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [gcc_pkg::REG_DATA_W-1:0]   wr_data,
  // item input
  input  logic                             start,
  output logic                             busy,
  input  logic                             has_edge,
  input  logic [5:0]                       source_vertex,
  input  logic [5:0]                       target_vertex,
  input  logic                             last_edge,
  // result
  output logic                             done,
  output logic [6:0]                       comparable_count
);
  import gcc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLOSE = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_COUNT = 4'b1000
  } state_t;

  localparam logic [VW-1:0] LAST_STEP = VW'(MAX_VERTICES - 1);

  state_t         state, state_next;
  logic [VW-1:0]  step;
  logic [CW-1:0]  count;
  logic [6:0]     vertex_count;
  logic           undirected_mode;
  logic [CW-1:0]  live_n;
  logic           accept;
  logic           step_end;
  logic           edge_ok;
  cell_ctl_t      ctl;
  row_t           pivot;

  cell_data_t links [MAX_VERTICES];
  cell_data_t helds [MAX_VERTICES];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= 7'(MAX_VERTICES);
      undirected_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_VERTEX_COUNT: vertex_count    <= wr_data[6:0];
        REG_UNDIRECTED:   undirected_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Vertex count clamped to 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == 7'd0) begin
      live_n = CW'(1);
    end else if ({1'b0, vertex_count} > 8'(MAX_VERTICES)) begin
      live_n = CW'(MAX_VERTICES);
    end else begin
      live_n = CW'(vertex_count);
    end
  end

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign step_end = (step == LAST_STEP);
  // edges with an endpoint outside the live vertex range are dropped
  assign edge_ok  = has_edge && ({1'b0, source_vertex} < live_n)
                    && ({1'b0, target_vertex} < live_n);

  // ---------------------------------------------------------------------------
  // Sequencer: load -> closure rotation -> check rotation -> count rotation
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && last_edge) state_next = ST_CLOSE;
      ST_CLOSE: if (step_end) state_next = ST_CHECK;
      ST_CHECK: if (step_end) state_next = ST_COUNT;
      ST_COUNT: if (step_end) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_IDLE) begin
        step  <= '0;
        count <= '0;
      end else begin
        step <= step_end ? '0 : step + VW'(1);
      end
      // count rotation: the head cell shows each row's flag once
      if (state == ST_COUNT) begin
        count <= count + CW'(helds[0].ok);
        if (step_end) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COUNT && step_end) begin
      comparable_count <= 7'(count + CW'(helds[0].ok));
    end
  end

  // ---------------------------------------------------------------------------
  // Cell control broadcast
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl          = '0;
    ctl.step     = step;
    ctl.live_n   = live_n;
    ctl.src      = source_vertex;
    ctl.dst      = target_vertex;
    ctl.wr_a     = accept && edge_ok;
    ctl.wr_b     = accept && edge_ok && undirected_mode;
    ctl.set_self = accept && last_edge;   // reflexive bit before the closure
    unique case (state)
      ST_IDLE:  ctl.mode = MODE_LOAD;
      ST_CLOSE: ctl.mode = MODE_CLOSE;
      ST_CHECK: ctl.mode = MODE_CHECK;
      ST_COUNT: ctl.mode = step_end ? MODE_CLEAR : MODE_SHIFT;
      default:  ctl.mode = MODE_LOAD;
    endcase
  end

  // During step k of a rotation the head cell holds row k: it is the pivot.
  assign pivot = helds[0].row;

  // ---------------------------------------------------------------------------
  // Ring of row cells; each takes its neighbor's updated contents
  // ---------------------------------------------------------------------------
  for (genvar c = 0; c < MAX_VERTICES; c++) begin : g_cell
    gcc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .id        (VW'(c)),
      .ctl       (ctl),
      .pivot     (pivot),
      .from_next (links[(c + 1) % MAX_VERTICES]),
      .data_out  (links[c]),
      .held      (helds[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_after_count: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_COUNT) && !busy)
    else $error("result strobe without a finished count rotation");

  a_last_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_edge) |=> (state == ST_CLOSE) && (step == '0))
    else $error("last item did not start the closure");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> (comparable_count <= 7'(MAX_VERTICES)))
    else $error("comparable count above vertex limit");

  a_cleared_after: assert property (@(posedge clk) disable iff (rst)
    done |-> (helds[0].row == '0) && (helds[MAX_VERTICES-1].row == '0))
    else $error("matrix not cleared after the result");

endmodule

### rtl/gcc_cell.sv
// ----------------------------------------------------------------------------
// gcc_cell: one row cell of the reachability ring
// Holds one matrix row; loads edges, applies the pivot update, checks
// comparability and hands its updated contents to the previous cell.
// ----------------------------------------------------------------------------
module gcc_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [gcc_pkg::VW-1:0]   id,
  input  gcc_pkg::cell_ctl_t       ctl,
  input  gcc_pkg::row_t            pivot,
  input  gcc_pkg::cell_data_t      from_next,
  output gcc_pkg::cell_data_t      data_out,
  output gcc_pkg::cell_data_t      held
);
  import gcc_pkg::*;

  cell_data_t cur;
  cell_data_t cur_next;
  row_t       load_bits;
  logic       own_k;
  logic       piv_i;
  logic       beyond;
  logic       id_live;

  assign own_k   = cur.row[ctl.step];
  assign piv_i   = pivot[cur.tag];
  assign beyond  = ({1'b0, ctl.step} >= ctl.live_n);
  assign id_live = ({1'b0, id} < ctl.live_n);
  assign held    = cur;

  always_comb begin
    load_bits = '0;
    if (ctl.wr_a && ctl.src == id) begin
      load_bits = load_bits | (row_t'(1) << ctl.dst);
    end
    if (ctl.wr_b && ctl.dst == id) begin
      load_bits = load_bits | (row_t'(1) << ctl.src);
    end
    if (ctl.set_self && id_live) begin
      load_bits = load_bits | (row_t'(1) << id);
    end
  end

  // value passed on to the neighbor
  always_comb begin
    data_out = cur;
    case (ctl.mode)
      MODE_CLOSE: begin
        // pivots past the live range carry stale edges and are skipped
        if (own_k && !beyond) data_out.row = cur.row | pivot;
      end
      MODE_CHECK: begin
        if (!(beyond || own_k || piv_i)) data_out.ok = 1'b0;
      end
      default: data_out = cur;
    endcase
  end

  always_comb begin
    cur_next = cur;
    unique case (ctl.mode) inside
      MODE_LOAD: begin
        cur_next.row = cur.row | load_bits;
        cur_next.tag = id;
        cur_next.ok  = id_live;
      end
      MODE_CLOSE, MODE_CHECK, MODE_SHIFT: cur_next = from_next;
      MODE_CLEAR: begin
        cur_next.row = '0;
        cur_next.tag = id;
        cur_next.ok  = 1'b0;
      end
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.row <= '0;
      cur.tag <= id;
      cur.ok  <= 1'b0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule
